// ===== hdl/ssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and fixed widths shared by the stop deceleration selector.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// widths sized for a window of up to 256 samples
	localparam int T_W    = 23;  // relative sample time, saturated
	localparam int ST_W   = 31;  // sum of t
	localparam int SV_W   = 24;  // sum of v
	localparam int TT_W   = 46;  // t*t
	localparam int TV_W   = 38;  // t*v
	localparam int STT_W  = 54;  // sum of t*t
	localparam int STV_W  = 46;  // sum of t*v
	localparam int DEN_W  = 64;
	localparam int NF_W   = 56;  // slope numerator
	localparam int NUM_W  = 89;  // root numerator
	localparam int REM_W  = 88;  // divider remainder
	localparam int D_W    = 64;  // divider divisor
	localparam int Q_W    = 20;  // quotient bits
	localparam int SQ_W   = 31;  // speed squared
	localparam int MUL_W  = 64;  // shared multiplier operand
	localparam int PROD_W = 128;

	localparam logic signed [31:0] REL_HI = 32'sd4194303;
	localparam logic signed [31:0] REL_LO = -32'sd4194303;
	localparam logic signed [31:0] HOLD_MS = 32'sd500;
	localparam logic [Q_W-1:0] STOP_SAT = '1;

	typedef enum logic [1:0] {
		CMD_INIT    = 2'd0,
		CMD_PUSH    = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		DEC_FAR    = 3'd0,
		DEC_NEAR   = 3'd1,
		DEC_STRONG = 3'd2,
		DEC_RUN    = 3'd3,
		DEC_HOLD   = 3'd4,
		DEC_STOP   = 3'd5
	} decision_t;

	typedef enum logic [2:0] {
		REG_FAR_DIST  = 3'd0,
		REG_NEAR_DIST = 3'd1,
		REG_HARD      = 3'd2,
		REG_SOFT      = 3'd3,
		REG_GENTLE    = 3'd4,
		REG_FAST      = 3'd5,
		REG_MOVING    = 3'd6,
		REG_STOP_TIME = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MOP_NSTT  = 3'd0,
		MOP_STST  = 3'd1,
		MOP_NSTV  = 3'd2,
		MOP_STSV  = 3'd3,
		MOP_STNF  = 3'd4,
		MOP_SVDEN = 3'd5,
		MOP_NNF   = 3'd6
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_INIT,
		ST_LOOP,
		ST_DRAIN,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_FIT_CHK,
		ST_NUM_CHK,
		ST_DIV_LOAD,
		ST_DIV_CHK,
		ST_DIV_STEP,
		ST_INIT_SET,
		ST_DECIDE
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    push_wr;
		logic    init_start;
		logic    strong_min;
		logic    issue;
		logic    mul_start;
		mul_op_t mul_op;
		logic    mul_wb;
		logic    set_known;
		logic    div_load;
		logic    div_init;
		logic    div_chk;
		logic    div_step;
		logic    init_set;
		logic    decide;
	} ctrl_cmd_t;

	typedef struct packed {
		logic dist_pos;
		logic pipe_busy;
		logic mul_done;
		logic fit_ok;
		logic num_ok;
		logic div_sat;
	} dp_status_t;

endpackage

// ===== hdl/ssd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/ssd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_mul
// Iterative signed 64x64 multiplier, four 32x32 partial products.
// ----------------------------------------------------------------------------
module ssd_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [ssd_pkg::MUL_W-1:0]     a,
	input  logic signed [ssd_pkg::MUL_W-1:0]     b,
	output logic                                 done,
	output logic signed [ssd_pkg::PROD_W-1:0]    p
);
	import ssd_pkg::*;

	logic [MUL_W-1:0]  am_q, bm_q;
	logic              neg_q;
	logic [PROD_W-1:0] acc_q;
	logic [63:0]       pp_q;
	logic [1:0]        sh_q;
	logic              ppv_q;
	logic [2:0]        step_q;
	logic              busy_q, done_q;
	logic [31:0]       a_half, b_half;
	logic [PROD_W-1:0] pp_shift;

	assign a_half = step_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = step_q[0] ? bm_q[63:32] : bm_q[31:0];

	always_comb begin
		unique case (sh_q)
			2'd0:    pp_shift = PROD_W'(pp_q);
			2'd1:    pp_shift = PROD_W'(pp_q) << 32;
			default: pp_shift = PROD_W'(pp_q) << 64;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ppv_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ppv_q  <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q < 3'd4) begin
					ppv_q  <= 1'b1;
					step_q <= step_q + 3'd1;
				end else if (step_q == 3'd4) begin
					ppv_q  <= 1'b0;
					step_q <= 3'd5;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[MUL_W-1] ? (~a + MUL_W'(1)) : a;
			bm_q  <= b[MUL_W-1] ? (~b + MUL_W'(1)) : b;
			neg_q <= a[MUL_W-1] ^ b[MUL_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (ppv_q) begin
				acc_q <= acc_q + pp_shift;
			end
			if (step_q < 3'd4) begin
				pp_q <= a_half * b_half;
				sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			end else if (step_q == 3'd5 && neg_q) begin
				acc_q <= ~acc_q + PROD_W'(1);
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

// ===== hdl/ssd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath: settings, sample window, fit sums, shared multiplier,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module ssd_dp #(
	parameter int HIST_DEPTH         = 16,
	parameter int MAX_STRONG_DECEL   = -512,
	parameter int MIN_STRONG_DECEL   = -2048,
	parameter int MOVING_ACCEL_LIMIT = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ssd_pkg::ctrl_cmd_t                     c,
	output ssd_pkg::dp_status_t                    st,
	input  logic [$clog2(HIST_DEPTH)-1:0]          wr_addr,
	input  logic [$clog2(HIST_DEPTH)-1:0]          rd_addr,
	input  logic [$clog2(HIST_DEPTH+1)-1:0]        n,
	input  logic [31:0]                            timestamp_ms,
	input  logic signed [15:0]                     speed,
	input  logic signed [23:0]                     distance,
	input  logic signed [15:0]                     accel,
	input  logic                                   cfg_write,
	input  logic [2:0]                             cfg_index,
	input  logic [23:0]                            cfg_data,
	output logic signed [15:0]                     accel_cmd,
	output logic [2:0]                             decision,
	output logic                                   stop_time_known,
	output logic [19:0]                            stop_time_ms
);
	import ssd_pkg::*;

	// settings
	logic signed [23:0] far_q, near_q;
	logic signed [15:0] hard_q, soft_q, gentle_q;
	logic [14:0]        fast_q, moving_q;
	logic [15:0]        stop_lim_q;

	// latched item
	logic [31:0]        now_q;
	logic signed [15:0] speed_q, accel_q;
	logic signed [23:0] dist_q;

	logic signed [15:0] strong_q;
	logic [31:0]        hold_q;
	logic [SQ_W-1:0]    sq_q;

	// window walk
	logic [47:0]             rd_data;
	logic                    v0_q, v1_q, v2_q;
	logic signed [31:0]      diff;
	logic signed [T_W-1:0]   t_c, t_s1;
	logic signed [15:0]      v_s1;
	logic signed [TT_W-1:0]  tt_s2;
	logic signed [TV_W-1:0]  tv_s2;
	logic signed [ST_W-1:0]  st_q;
	logic signed [SV_W-1:0]  sv_q;
	logic signed [STT_W-1:0] stt_q;
	logic signed [STV_W-1:0] stv_q;

	// fit
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     mul_done;
	logic signed [NUM_W-1:0]  pa_q, num_q;
	logic signed [DEN_W-1:0]  den_q;
	logic signed [NF_W-1:0]   nf_q;
	logic [NF_W-1:0]          nf_mag;
	logic [D_W-1:0]           d_q;
	logic [NUM_W-1:0]         num_neg;
	logic [REM_W-1:0]         num_mag;

	// divider
	logic [REM_W-1:0] rem_q, dsh_q;
	logic [Q_W-1:0]   q_q;
	logic             sat_q, known_q;
	logic [D_W-1:0]   dsrc;

	// decision
	logic signed [Q_W+1:0] negq;
	logic signed [15:0]    strong_nxt;
	logic [16:0]           speed_mag, accel_mag;
	logic                  fast, running, late;
	logic signed [31:0]    elapsed;
	logic signed [15:0]    res;
	decision_t             dec;

	logic signed [15:0] accel_cmd_q;
	decision_t          decision_q;
	logic               known_out_q;
	logic [Q_W-1:0]     stop_q;

	ssd_ram #(
		.WIDTH(48),
		.DEPTH(HIST_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (c.push_wr),
		.waddr(wr_addr),
		.wdata({now_q, speed_q}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	ssd_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (c.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_q      <= -24'sd512;
			near_q     <= -24'sd307;
			hard_q     <= -16'sd3482;
			soft_q     <= -16'sd819;
			gentle_q   <= -16'sd307;
			fast_q     <= 15'd512;
			moving_q   <= 15'd10;
			stop_lim_q <= 16'd970;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FAR_DIST:  far_q      <= cfg_data;
				REG_NEAR_DIST: near_q     <= cfg_data;
				REG_HARD:      hard_q     <= cfg_data[15:0];
				REG_SOFT:      soft_q     <= cfg_data[15:0];
				REG_GENTLE:    gentle_q   <= cfg_data[15:0];
				REG_FAST:      fast_q     <= cfg_data[14:0];
				REG_MOVING:    moving_q   <= cfg_data[14:0];
				REG_STOP_TIME: stop_lim_q <= cfg_data[15:0];
			endcase
		end
	end

	// relative sample time, saturated
	assign diff = rd_data[47:16] - now_q;
	always_comb begin
		if (diff > REL_HI) begin
			t_c = T_W'(REL_HI);
		end else if (diff < REL_LO) begin
			t_c = T_W'(REL_LO);
		end else begin
			t_c = diff[T_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q     <= 1'b0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			strong_q <= 16'(MIN_STRONG_DECEL);
			hold_q   <= '0;
			known_q  <= 1'b0;
		end else begin
			v0_q <= c.issue;
			v1_q <= v0_q;
			v2_q <= v1_q;
			if (c.init_start) begin
				hold_q <= now_q;
			end else if (c.decide && dec == DEC_RUN) begin
				hold_q <= now_q;
			end
			if (c.strong_min) begin
				strong_q <= 16'(MIN_STRONG_DECEL);
			end else if (c.init_set) begin
				strong_q <= strong_nxt;
			end
			if (c.load) begin
				known_q <= 1'b0;
			end else if (c.set_known) begin
				known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c.load) begin
			now_q   <= timestamp_ms;
			speed_q <= speed;
			dist_q  <= distance;
			accel_q <= accel;
			st_q    <= '0;
			sv_q    <= '0;
			stt_q   <= '0;
			stv_q   <= '0;
		end else begin
			if (v1_q) begin
				st_q <= st_q + ST_W'(t_s1);
				sv_q <= sv_q + SV_W'(v_s1);
			end
			if (v2_q) begin
				stt_q <= stt_q + STT_W'(tt_s2);
				stv_q <= stv_q + STV_W'(tv_s2);
			end
		end
		t_s1  <= t_c;
		v_s1  <= rd_data[15:0];
		tt_s2 <= t_s1 * t_s1;
		tv_s2 <= t_s1 * v_s1;
		if (c.init_start) begin
			sq_q <= SQ_W'(32'(speed_q) * 32'(speed_q));
		end
	end

	assign nf_mag = nf_q[NF_W-1] ? (~nf_q + NF_W'(1)) : nf_q;

	always_comb begin
		unique case (c.mul_op)
			MOP_NSTT:  begin mul_a = MUL_W'(n);    mul_b = MUL_W'(stt_q); end
			MOP_STST:  begin mul_a = MUL_W'(st_q); mul_b = MUL_W'(st_q);  end
			MOP_NSTV:  begin mul_a = MUL_W'(n);    mul_b = MUL_W'(stv_q); end
			MOP_STSV:  begin mul_a = MUL_W'(st_q); mul_b = MUL_W'(sv_q);  end
			MOP_STNF:  begin mul_a = MUL_W'(st_q); mul_b = MUL_W'(nf_q);  end
			MOP_SVDEN: begin mul_a = MUL_W'(sv_q); mul_b = den_q;          end
			MOP_NNF:   begin mul_a = MUL_W'(n);    mul_b = MUL_W'(nf_mag); end
			default:   begin mul_a = '0;           mul_b = '0;             end
		endcase
	end

	always_ff @(posedge clk) begin
		if (c.mul_wb) begin
			unique case (c.mul_op)
				MOP_NSTT:  pa_q  <= prod[NUM_W-1:0];
				MOP_STST:  den_q <= pa_q[DEN_W-1:0] - prod[DEN_W-1:0];
				MOP_NSTV:  pa_q  <= prod[NUM_W-1:0];
				MOP_STSV:  nf_q  <= NF_W'(pa_q[DEN_W-1:0] - prod[DEN_W-1:0]);
				MOP_STNF:  pa_q  <= prod[NUM_W-1:0];
				MOP_SVDEN: num_q <= pa_q - prod[NUM_W-1:0];
				MOP_NNF:   d_q   <= prod[D_W-1:0];
				default:   ;
			endcase
		end
	end

	assign num_neg = ~num_q + NUM_W'(1);
	assign num_mag = num_q[NUM_W-1] ? num_neg[REM_W-1:0] : num_q[REM_W-1:0];
	assign dsrc    = c.div_init ? D_W'({dist_q, 1'b0}) : d_q;

	// restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (c.div_load) begin
			rem_q <= c.div_init ? REM_W'(sq_q) : num_mag;
			dsh_q <= REM_W'(dsrc) << Q_W;
			q_q   <= '0;
		end else if (c.div_chk) begin
			sat_q <= rem_q >= dsh_q;
			dsh_q <= dsh_q >> 1;
		end else if (c.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// strong decel from floor(v^2 / 2d), clamped
	assign negq = -$signed({2'b00, q_q});
	always_comb begin
		if (sat_q) begin
			strong_nxt = 16'(MIN_STRONG_DECEL);
		end else if (negq > (Q_W+2)'(MAX_STRONG_DECEL)) begin
			strong_nxt = 16'(MAX_STRONG_DECEL);
		end else if (negq < (Q_W+2)'(MIN_STRONG_DECEL)) begin
			strong_nxt = 16'(MIN_STRONG_DECEL);
		end else begin
			strong_nxt = negq[15:0];
		end
	end

	assign speed_mag = speed_q[15] ? -{speed_q[15], speed_q} : {1'b0, speed_q};
	assign accel_mag = accel_q[15] ? -{accel_q[15], accel_q} : {1'b0, accel_q};
	assign fast      = speed_mag > 17'(fast_q);
	assign running   = speed_mag > 17'(moving_q) || accel_mag > 17'(MOVING_ACCEL_LIMIT);
	assign late      = sat_q || q_q > Q_W'(stop_lim_q) ||
	                   (q_q == Q_W'(stop_lim_q) && rem_q != '0);
	assign elapsed   = now_q - hold_q;

	always_comb begin
		priority if (dist_q < far_q) begin
			res = hard_q;   dec = DEC_FAR;
		end else if (dist_q < near_q) begin
			res = soft_q;   dec = DEC_NEAR;
		end else if (running) begin
			if ((known_q && late) || (!known_q && fast)) begin
				res = strong_q; dec = DEC_STRONG;
			end else begin
				res = gentle_q; dec = DEC_RUN;
			end
		end else if (elapsed < HOLD_MS) begin
			res = gentle_q; dec = DEC_HOLD;
		end else begin
			res = hard_q;   dec = DEC_STOP;
		end
	end

	always_ff @(posedge clk) begin
		if (c.decide) begin
			accel_cmd_q <= res;
			decision_q  <= dec;
			known_out_q <= known_q;
			stop_q      <= !known_q ? '0 : (sat_q ? STOP_SAT : q_q);
		end
	end

	assign st.dist_pos  = dist_q > 24'sd0;
	assign st.pipe_busy = v0_q | v1_q | v2_q;
	assign st.mul_done  = mul_done;
	assign st.fit_ok    = den_q != '0 && nf_q != '0;
	assign st.num_ok    = num_q != '0 && num_q[NUM_W-1] == nf_q[NF_W-1];
	assign st.div_sat   = sat_q;

	assign accel_cmd       = accel_cmd_q;
	assign decision        = decision_q;
	assign stop_time_known = known_out_q;
	assign stop_time_ms    = stop_q;
endmodule

// ===== hdl/ssd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ctrl
// Controller: command decode, window addressing, multiply and divide
// sequencing, result handshake.
// ----------------------------------------------------------------------------
module ssd_ctrl #(
	parameter int HIST_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ssd_pkg::ctrl_cmd_t                  c,
	input  ssd_pkg::dp_status_t                 st,
	output logic [$clog2(HIST_DEPTH)-1:0]       wr_addr,
	output logic [$clog2(HIST_DEPTH)-1:0]       rd_addr,
	output logic [$clog2(HIST_DEPTH+1)-1:0]     n
);
	import ssd_pkg::*;

	localparam int AW = $clog2(HIST_DEPTH);
	localparam int CW = $clog2(HIST_DEPTH+1);

	ctrl_state_t   state_q, nxt;
	logic [AW-1:0] slot_q, idx_q;
	logic [CW-1:0] count_q;
	logic [4:0]    step_q;
	mul_op_t       mop_q;
	logic          init_q, out_valid_q;
	logic          last_idx;

	assign last_idx = CW'(idx_q) == count_q - CW'(1);

	always_comb begin
		nxt      = state_q;
		c        = '0;
		c.mul_op = mop_q;
		c.div_init = init_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					c.load = 1'b1;
					unique case (cmd_t'(cmd))
						CMD_INIT:    nxt = ST_INIT;
						CMD_PUSH:    nxt = ST_PUSH;
						CMD_COMPUTE: nxt = (count_q == '0) ? ST_DECIDE : ST_LOOP;
						CMD_NONE:    nxt = ST_IDLE;
					endcase
				end
			end
			ST_PUSH: begin
				c.push_wr = 1'b1;
				nxt = ST_IDLE;
			end
			ST_INIT: begin
				c.init_start = 1'b1;
				if (!st.dist_pos) begin
					c.strong_min = 1'b1;
					nxt = ST_IDLE;
				end else begin
					nxt = ST_DIV_LOAD;
				end
			end
			ST_LOOP: begin
				c.issue = 1'b1;
				if (last_idx) begin
					nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.pipe_busy) begin
					nxt = ST_MUL_GO;
				end
			end
			ST_MUL_GO: begin
				c.mul_start = 1'b1;
				nxt = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (st.mul_done) begin
					c.mul_wb = 1'b1;
					priority if (mop_q == MOP_STSV) begin
						nxt = ST_FIT_CHK;
					end else if (mop_q == MOP_NNF) begin
						nxt = ST_NUM_CHK;
					end else begin
						nxt = ST_MUL_GO;
					end
				end
			end
			ST_FIT_CHK: begin
				nxt = st.fit_ok ? ST_MUL_GO : ST_DECIDE;
			end
			ST_NUM_CHK: begin
				if (st.num_ok) begin
					c.set_known = 1'b1;
					nxt = ST_DIV_LOAD;
				end else begin
					nxt = ST_DECIDE;
				end
			end
			ST_DIV_LOAD: begin
				c.div_load = 1'b1;
				nxt = ST_DIV_CHK;
			end
			ST_DIV_CHK: begin
				c.div_chk = 1'b1;
				nxt = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				if (st.div_sat) begin
					nxt = init_q ? ST_INIT_SET : ST_DECIDE;
				end else begin
					c.div_step = 1'b1;
					if (step_q == 5'(Q_W - 1)) begin
						nxt = init_q ? ST_INIT_SET : ST_DECIDE;
					end
				end
			end
			ST_INIT_SET: begin
				c.init_set = 1'b1;
				nxt = ST_IDLE;
			end
			ST_DECIDE: begin
				if (!out_valid_q || !out_stall) begin
					c.decide = 1'b1;
					nxt = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			mop_q       <= MOP_NSTT;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (c.load) begin
				idx_q  <= '0;
				mop_q  <= MOP_NSTT;
				init_q <= cmd_t'(cmd) == CMD_INIT;
			end
			if (c.push_wr) begin
				slot_q <= (slot_q == AW'(HIST_DEPTH - 1)) ? '0 : slot_q + AW'(1);
				if (count_q != CW'(HIST_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (c.issue) begin
				idx_q <= idx_q + AW'(1);
			end
			if (c.mul_wb && mop_q != MOP_NNF) begin
				mop_q <= mul_op_t'(mop_q + 3'd1);
			end
			if (c.div_chk) begin
				step_q <= '0;
			end else if (c.div_step) begin
				step_q <= step_q + 5'd1;
			end
			if (c.decide) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign wr_addr   = slot_q;
	assign rd_addr   = idx_q;
	assign n         = count_q;
endmodule

// ===== hdl/smooth_stop_decel_selector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_stop_decel_selector_unit
// Stop deceleration selector: strong decel setup, speed window, line fit
// and acceleration choice.
// ----------------------------------------------------------------------------
// One item at a time. Init, for a positive distance, runs a radix-2
// divide of v^2 by 2d of up to 20 steps. Compute walks the n samples
// of the window in the sample RAM, forms up to seven wide products on one
// shared multiplier built from 32x32 partial products, and uses the
// same 20-step divider for the stop time. A finished result sits in
// the output register while the next item is taken; a compute waits
// at its end only if the previous result is still stalled.
// No clearing pass: window slots are only read after being written.
module smooth_stop_decel_selector_unit #(
	parameter int HIST_DEPTH         = 16,
	parameter int MAX_STRONG_DECEL   = -512,
	parameter int MIN_STRONG_DECEL   = -2048,
	parameter int MOVING_ACCEL_LIMIT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [31:0]        timestamp_ms,
	input  logic signed [15:0] speed,
	input  logic signed [23:0] distance,
	input  logic signed [15:0] accel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] accel_cmd,
	output logic [2:0]         decision,
	output logic               stop_time_known,
	output logic [19:0]        stop_time_ms,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import ssd_pkg::*;

	ctrl_cmd_t                     c;
	dp_status_t                    st;
	logic [$clog2(HIST_DEPTH)-1:0]   wr_addr, rd_addr;
	logic [$clog2(HIST_DEPTH+1)-1:0] n;

	ssd_ctrl #(
		.HIST_DEPTH(HIST_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.c        (c),
		.st       (st),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.n        (n)
	);

	ssd_dp #(
		.HIST_DEPTH        (HIST_DEPTH),
		.MAX_STRONG_DECEL  (MAX_STRONG_DECEL),
		.MIN_STRONG_DECEL  (MIN_STRONG_DECEL),
		.MOVING_ACCEL_LIMIT(MOVING_ACCEL_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.c              (c),
		.st             (st),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr),
		.n              (n),
		.timestamp_ms   (timestamp_ms),
		.speed          (speed),
		.distance       (distance),
		.accel          (accel),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accel_cmd      (accel_cmd),
		.decision       (decision),
		.stop_time_known(stop_time_known),
		.stop_time_ms   (stop_time_ms)
	);

	// no stop time predicted means a zero stop time field
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stop_time_known |-> stop_time_ms == '0)
		else $error("stop time set without a prediction");

	// init, push and none beats never produce a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_COMPUTE && !out_valid |=> !out_valid)
		else $error("result from a command that has none");

	// a real command keeps the input stalled once it has been accepted
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_NONE |=> in_stall)
		else $error("accepted a beat while busy");
endmodule
